>>> rtl/assert_macros.svh
// assertion macros used by the accumulator rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/rsa_pkg.sv
// constants and types for the running statistics accumulator
`timescale 1ns / 1ps

package rsa_pkg;

	localparam int unsigned SAMPLE_WIDTH_DEF = 32;
	localparam int unsigned COUNT_WIDTH_DEF  = 32;
	localparam int unsigned FRAC_BITS_DEF    = 16;

	localparam int unsigned VAL_W  = 32;
	localparam int unsigned SUM_W  = 64;
	localparam int unsigned MEAN_W = 48;
	localparam int unsigned QUO_W  = MEAN_W + 1;

	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned IN_USER_W  = 1;
	localparam int unsigned OUT_FIELD_W = 5 * VAL_W + 2 * SUM_W + MEAN_W + 2;
	localparam int unsigned OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int unsigned OUT_USER_W  = 1;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_ACC  = 7'b0000010,
		ST_SUM  = 7'b0000100,
		ST_ABS  = 7'b0001000,
		ST_DIV  = 7'b0010000,
		ST_NEG  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

endpackage

>>> rtl/running_statistics_accumulator.sv
// running statistics accumulator top level with shared 64-bit adder sequencer
`timescale 1ns / 1ps
`include "assert_macros.svh"

// A sample transfer is accepted and then applied in the update state, and a report
// transfer keeps the block busy from accept until its result is loaded into the
// output register: the mean is found by a restoring divider that retires one
// quotient bit per cycle over 64 + FRAC_BITS bits, and the total, its magnitude,
// every divide step and the final sign all go through one shared 64-bit adder.
// The result sits in an output register, so sample transfers keep flowing while a
// report waits to be taken. The mean is truncated toward zero and clamped to the
// 48-bit signed range; a report with no samples carries only the no-data flag.

module running_statistics_accumulator #(
	parameter int unsigned SAMPLE_WIDTH = rsa_pkg::SAMPLE_WIDTH_DEF,
	parameter int unsigned COUNT_WIDTH  = rsa_pkg::COUNT_WIDTH_DEF,
	parameter int unsigned FRAC_BITS    = rsa_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// sample
	input  logic [rsa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// kind
	input  logic [rsa_pkg::IN_USER_W-1:0]   s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// max_value, min_value, sample_count, positive_count, negative_count,
	// odd_total, even_total, mean_value, ends_equal, count_saturated, zero pad
	output logic [rsa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// no_data
	output logic [rsa_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

	import rsa_pkg::*;

	localparam int unsigned DIV_BITS = SUM_W + FRAC_BITS;
	localparam int unsigned STEP_W   = $clog2(DIV_BITS);
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [VAL_W-1:0] LARGEST_RST =
		{{(VAL_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};
	localparam logic [VAL_W-1:0] SMALLEST_RST =
		{{(VAL_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
	localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(1) << (MEAN_W - 1);
	localparam logic [QUO_W-1:0] POS_LIM = NEG_LIM - QUO_W'(1);

	state_t                  state_q;
	logic [VAL_W-1:0]        sample_q;
	logic [VAL_W-1:0]        largest_q;
	logic [VAL_W-1:0]        smallest_q;
	logic [VAL_W-1:0]        first_q;
	logic [VAL_W-1:0]        last_q;
	logic [COUNT_WIDTH-1:0]  count_q;
	logic [COUNT_WIDTH-1:0]  pos_q;
	logic [COUNT_WIDTH-1:0]  neg_q;
	logic [SUM_W-1:0]        odd_q;
	logic [SUM_W-1:0]        even_q;
	logic                    sat_q;
	logic [SUM_W-1:0]        div_q;
	logic                    sign_q;
	logic [COUNT_WIDTH-1:0]  rem_q;
	logic [QUO_W-1:0]        quo_q;
	logic                    ovf_q;
	logic [STEP_W-1:0]       step_q;
	logic [MEAN_W-1:0]       mean_q;
	logic                    out_vld_q;
	logic [OUT_DATA_W-1:0]   out_data_q;
	logic                    out_nodata_q;

	logic [SUM_W-1:0]        add_a;
	logic [SUM_W-1:0]        add_b;
	logic                    add_c;
	logic [SUM_W-1:0]        add_sum;
	logic [COUNT_WIDTH:0]    rem_sh;
	logic [QUO_W-1:0]        cap_mag;
	logic                    accept;
	logic                    out_free;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_free      = !out_vld_q || m_axis_tready;
	assign rem_sh        = {rem_q, div_q[SUM_W-1]};

	// clamp before the sign is applied
	always_comb begin
		if (sign_q) begin
			cap_mag = (ovf_q || quo_q > NEG_LIM) ? NEG_LIM : quo_q;
		end else begin
			cap_mag = (ovf_q || quo_q > POS_LIM) ? POS_LIM : quo_q;
		end
	end

	// shared adder operand select
	always_comb begin
		add_a = '0;
		add_b = '0;
		add_c = 1'b0;
		case (state_q)
			ST_ACC: begin
				add_a = sample_q[0] ? odd_q : even_q;
				add_b = SUM_W'($signed(sample_q));
			end
			ST_SUM: begin
				add_a = odd_q;
				add_b = even_q;
			end
			ST_ABS: begin
				add_a = sign_q ? ~div_q : div_q;
				add_c = sign_q;
			end
			ST_DIV: begin
				add_a = SUM_W'(rem_sh);
				add_b = ~(SUM_W'(count_q));
				add_c = 1'b1;
			end
			ST_NEG: begin
				add_a = sign_q ? ~(SUM_W'(cap_mag)) : SUM_W'(cap_mag);
				add_c = sign_q;
			end
			default: begin
				add_a = '0;
			end
		endcase
	end

	assign add_sum = add_a + add_b + SUM_W'(add_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			largest_q  <= LARGEST_RST;
			smallest_q <= SMALLEST_RST;
			first_q    <= '0;
			last_q     <= '0;
			count_q    <= '0;
			pos_q      <= '0;
			neg_q      <= '0;
			odd_q      <= '0;
			even_q     <= '0;
			sat_q      <= 1'b0;
			out_vld_q  <= 1'b0;
			step_q     <= '0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_axis_tuser[0] == KIND_SAMPLE) begin
							state_q <= ST_ACC;
						end else if (count_q == '0) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_SUM;
						end
					end
				end
				ST_ACC: begin
					if (count_q == CNT_MAX) begin
						sat_q <= 1'b1;
					end else begin
						if (count_q == '0) begin
							first_q <= sample_q;
						end
						last_q  <= sample_q;
						count_q <= count_q + CNT_ONE;
						if ($signed(sample_q) > $signed(largest_q)) begin
							largest_q <= sample_q;
						end
						if ($signed(sample_q) < $signed(smallest_q)) begin
							smallest_q <= sample_q;
						end
						if (sample_q[VAL_W-1]) begin
							neg_q <= neg_q + CNT_ONE;
						end else if (sample_q != '0) begin
							pos_q <= pos_q + CNT_ONE;
						end
						if (sample_q[0]) begin
							odd_q <= add_sum;
						end else begin
							even_q <= add_sum;
						end
					end
					state_q <= ST_IDLE;
				end
				ST_SUM: begin
					state_q <= ST_ABS;
				end
				ST_ABS: begin
					step_q  <= STEP_W'(DIV_BITS - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0) begin
						state_q <= ST_NEG;
					end
				end
				ST_NEG: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= VAL_W'($signed(s_axis_tdata[SAMPLE_WIDTH-1:0]));
		end
		case (state_q)
			ST_SUM: begin
				div_q  <= add_sum;
				sign_q <= add_sum[SUM_W-1];
			end
			ST_ABS: begin
				div_q <= add_sum;
				rem_q <= '0;
				quo_q <= '0;
				ovf_q <= 1'b0;
			end
			ST_DIV: begin
				div_q <= {div_q[SUM_W-2:0], 1'b0};
				ovf_q <= ovf_q | quo_q[QUO_W-1];
				if (!add_sum[SUM_W-1]) begin
					rem_q <= add_sum[COUNT_WIDTH-1:0];
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[COUNT_WIDTH-1:0];
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
			end
			ST_NEG: begin
				mean_q <= add_sum[MEAN_W-1:0];
			end
			ST_OUT: begin
				if (out_free) begin
					if (count_q == '0) begin
						out_data_q   <= '0;
						out_nodata_q <= 1'b1;
					end else begin
						out_data_q <= OUT_DATA_W'({
							sat_q,
							(first_q == last_q),
							mean_q,
							even_q,
							odd_q,
							VAL_W'(neg_q),
							VAL_W'(pos_q),
							VAL_W'(count_q),
							smallest_q,
							largest_q
						});
						out_nodata_q <= 1'b0;
					end
				end
			end
			default: begin
				div_q <= div_q;
			end
		endcase
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_nodata_q;

	`ASSERT_NEXT(a_acc_next, clk, arst_n, (accept && s_axis_tuser[0] == KIND_SAMPLE), (state_q == ST_ACC))
	`ASSERT_NEXT(a_cnt_mono, clk, arst_n, 1'b1, (count_q >= $past(count_q)))
	`ASSERT_NEXT(a_sat_hold, clk, arst_n, sat_q, sat_q)
	`ASSERT_IMPL(a_sign_cnt, clk, arst_n, 1'b1, (({1'b0, pos_q} + {1'b0, neg_q}) <= {1'b0, count_q}))
	`ASSERT_IMPL(a_out_src, clk, arst_n, $rose(out_vld_q), ($past(state_q) == ST_OUT))

endmodule

>>> tb/tb.sv
// self-checking testbench for the running statistics accumulator
`timescale 1ns / 1ps

module tb;
	import rsa_pkg::*;

	localparam int HOLD_CYCLES   = 1500;
	localparam int PHASE_ITEMS   = 475;
	localparam int DRAIN_CYCLES  = 200;
	localparam logic [63:0] MEAN_NEG_LIM = 64'h0000_8000_0000_0000;
	localparam logic [63:0] MEAN_POS_LIM = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [31:0] COUNT_FULL   = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        no_data;
		logic [31:0] max_v;
		logic [31:0] min_v;
		logic [31:0] cnt;
		logic [31:0] pos;
		logic [31:0] neg;
		logic [63:0] odd_t;
		logic [63:0] even_t;
		logic [47:0] mean;
		logic        ends_eq;
		logic        sat;
	} stats_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] smp;
		logic        typed;
		stats_t      want;
	} stim_row_t;

	localparam stats_t NO_DATA_STATS = '{1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
		64'd0, 64'd0, 48'd0, 1'b0, 1'b0};
	localparam stats_t ONE_MIN_STATS = '{1'b0, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd0,
		32'd1, 64'd0, 64'hFFFF_FFFF_8000_0000, 48'h8000_0000_0000, 1'b1, 1'b0};
	localparam stats_t NONE = '0;

	localparam int DIR_ROWS = 20;
	localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
		'{KIND_REPORT, 32'h0000_0000, 1'b1, NO_DATA_STATS},
		'{KIND_SAMPLE, 32'h8000_0000, 1'b0, NONE},
		'{KIND_REPORT, 32'hFFFF_FFFF, 1'b1, ONE_MIN_STATS},
		'{KIND_SAMPLE, 32'h7FFF_FFFF, 1'b0, NONE},
		'{KIND_REPORT, 32'h0000_0000, 1'b0, NONE},
		'{KIND_SAMPLE, 32'h0000_0000, 1'b0, NONE},
		'{KIND_SAMPLE, 32'hFFFF_FFFF, 1'b0, NONE},
		'{KIND_SAMPLE, 32'h0000_0001, 1'b0, NONE},
		'{KIND_REPORT, 32'h5555_5555, 1'b0, NONE},
		'{KIND_SAMPLE, 32'h0000_0002, 1'b0, NONE},
		'{KIND_SAMPLE, 32'hFFFF_FFFE, 1'b0, NONE},
		'{KIND_SAMPLE, 32'h5555_5555, 1'b0, NONE},
		'{KIND_SAMPLE, 32'hAAAA_AAAA, 1'b0, NONE},
		'{KIND_REPORT, 32'hAAAA_AAAA, 1'b0, NONE},
		'{KIND_SAMPLE, 32'h8000_0000, 1'b0, NONE},
		'{KIND_REPORT, 32'h0000_0000, 1'b0, NONE},
		'{KIND_REPORT, 32'h0000_0000, 1'b0, NONE},
		'{KIND_SAMPLE, 32'h7FFF_FFFE, 1'b0, NONE},
		'{KIND_SAMPLE, 32'h8000_0001, 1'b0, NONE},
		'{KIND_REPORT, 32'h0000_0000, 1'b0, NONE}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata;
	logic [IN_USER_W-1:0]   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic [OUT_USER_W-1:0]  m_axis_tuser;

	// statistics held by the predictor
	logic [31:0] hi_mark, lo_mark, n_samples, n_pos, n_neg, first_smp, last_smp;
	logic [63:0] odd_acc, even_acc;
	logic        full_seen;

	stats_t expected_reports [$];
	int     idle_pct, stall_pct, mismatches;
	logic   hold_req;
	logic   hold_done;

	running_statistics_accumulator uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [47:0] fixed_mean(input logic [63:0] total, input logic [63:0] n);
		logic        is_neg;
		logic [63:0] mag, q, r, m;
		is_neg = total[63];
		mag = is_neg ? (64'd0 - total) : total;
		q = mag / n;
		r = mag % n;
		if (q > (MEAN_NEG_LIM >> FRAC_BITS_DEF))
			m = MEAN_NEG_LIM;
		else
			m = (q << FRAC_BITS_DEF) + ((r << FRAC_BITS_DEF) / n);
		if (is_neg) begin
			if (m > MEAN_NEG_LIM)
				m = MEAN_NEG_LIM;
			m = 64'd0 - m;
		end else if (m > MEAN_POS_LIM) begin
			m = MEAN_POS_LIM;
		end
		return m[47:0];
	endfunction

	function automatic stats_t current_stats();
		stats_t st;
		st = '0;
		if (n_samples == 32'd0) begin
			st.no_data = 1'b1;
		end else begin
			st.max_v   = hi_mark;
			st.min_v   = lo_mark;
			st.cnt     = n_samples;
			st.pos     = n_pos;
			st.neg     = n_neg;
			st.odd_t   = odd_acc;
			st.even_t  = even_acc;
			st.mean    = fixed_mean(odd_acc + even_acc, {32'd0, n_samples});
			st.ends_eq = (first_smp == last_smp);
			st.sat     = full_seen;
		end
		return st;
	endfunction

	task automatic absorb_sample(input logic [31:0] smp);
		logic [63:0] wide;
		wide = {{32{smp[31]}}, smp};
		if (n_samples == COUNT_FULL) begin
			full_seen = 1'b1;
		end else begin
			if (n_samples == 32'd0)
				first_smp = smp;
			last_smp = smp;
			n_samples = n_samples + 32'd1;
			if ($signed(smp) > $signed(hi_mark))
				hi_mark = smp;
			if ($signed(smp) < $signed(lo_mark))
				lo_mark = smp;
			if ($signed(smp) > 0)
				n_pos = n_pos + 32'd1;
			else if ($signed(smp) < 0)
				n_neg = n_neg + 32'd1;
			if (smp[0])
				odd_acc = odd_acc + wide;
			else
				even_acc = even_acc + wide;
		end
	endtask

	// drive one item, wait for its transfer, then update the predictor (sample) or queue the expected report
	task automatic offer_item(input logic kind, input logic [31:0] smp, input logic typed,
		input stats_t want);
		int gap;
		gap = 0;
		if ($urandom_range(99) < idle_pct)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = smp;
		s_axis_tuser  = kind;
		do @(posedge clk); while (!s_axis_tready);
		if (kind == KIND_REPORT)
			expected_reports.push_back(typed ? want : current_stats());
		else
			absorb_sample(smp);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_sample();
		logic [31:0] v;
		case ($urandom_range(9))
			0, 1, 2, 3: v = $urandom;
			4, 5: v = $urandom_range(200) - 100;
			6: begin
				case ($urandom_range(6))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'h0000_0000;
					3: v = 32'hFFFF_FFFF;
					4: v = 32'h0000_0001;
					5: v = 32'h8000_0001;
					default: v = 32'h7FFF_FFFE;
				endcase
			end
			7: v = first_smp;
			8: v = $urandom >> $urandom_range(31);
			default: v = -($urandom >> $urandom_range(31));
		endcase
		return v;
	endfunction

	task automatic random_items(input int n);
		logic kind;
		for (int i = 0; i < n; i++) begin
			kind = ($urandom_range(7) == 0) ? KIND_REPORT : KIND_SAMPLE;
			offer_item(kind, (kind == KIND_REPORT) ? $urandom : pick_sample(), 1'b0, NONE);
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t mismatch %s: expected %h, got %h", $time, name, want, got);
		end
	endtask

	// sink side: random stalls, plus one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			m_axis_tready = ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		stats_t want, got;
		if (m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tdata[63:32],
				m_axis_tdata[95:64], m_axis_tdata[127:96], m_axis_tdata[159:128],
				m_axis_tdata[223:160], m_axis_tdata[287:224], m_axis_tdata[335:288],
				m_axis_tdata[336], m_axis_tdata[337]};
			if (expected_reports.size() == 0) begin
				mismatches++;
				$display("%0t unexpected transfer: expected none, got %h", $time, got);
			end else begin
				want = expected_reports.pop_front();
				check_field("no_data", want.no_data, got.no_data);
				check_field("max_value", want.max_v, got.max_v);
				check_field("min_value", want.min_v, got.min_v);
				check_field("sample_count", want.cnt, got.cnt);
				check_field("positive_count", want.pos, got.pos);
				check_field("negative_count", want.neg, got.neg);
				check_field("odd_total", want.odd_t, got.odd_t);
				check_field("even_total", want.even_t, got.even_t);
				check_field("mean_value", want.mean, got.mean);
				check_field("ends_equal", want.ends_eq, got.ends_eq);
				check_field("count_saturated", want.sat, got.sat);
			end
		end
	end

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		hold_req = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		mismatches = 0;
		hi_mark = 32'h8000_0000;
		lo_mark = 32'h7FFF_FFFF;
		n_samples = '0;
		n_pos = '0;
		n_neg = '0;
		first_smp = '0;
		last_smp = '0;
		odd_acc = '0;
		even_acc = '0;
		full_seen = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			offer_item(DIR_TABLE[i].kind, DIR_TABLE[i].smp, DIR_TABLE[i].typed,
				DIR_TABLE[i].want);

		random_items(PHASE_ITEMS);
		idle_pct = 59;
		random_items(PHASE_ITEMS);

		// long sink hold-off while reports keep coming, so the input backs up
		idle_pct = 0;
		hold_req = 1'b1;
		for (int i = 0; i < 30; i++)
			offer_item((i % 6 == 0) ? KIND_REPORT : KIND_SAMPLE, pick_sample(), 1'b0, NONE);

		idle_pct = 0;
		stall_pct = 59;
		random_items(PHASE_ITEMS);
		idle_pct = 24;
		stall_pct = 24;
		random_items(PHASE_ITEMS);
		s_axis_tvalid = 1'b0;

		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/rsa_pkg.sv
rtl/running_statistics_accumulator.sv
tb/tb.sv
